// File: sv/sirt_pkg.sv
package sirt_pkg;

   localparam int TIME_BITS   = 12;
   localparam int TAG_IN_BITS = 16;
   localparam int COUNT_BITS  = 5;

   typedef enum logic [1:0] {
      OP_INSERT   = 2'd0,
      OP_REMOVE   = 2'd1,
      OP_FIND     = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_TAKEN   = 3'd1,
      STATUS_ILLEGAL = 3'd2,
      STATUS_FULL    = 3'd3,
      STATUS_MISSING = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      STATE_IDLE,
      STATE_SCAN,
      STATE_SHIFT,
      STATE_PLACE,
      STATE_DONE
   } state_type;

endpackage

// File: sv/sirt_if.sv
interface sirt_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic [sirt_pkg::TIME_BITS-1:0]      start_time;
   logic [sirt_pkg::TIME_BITS-1:0]      end_time;
   logic [sirt_pkg::TAG_IN_BITS-1:0]    entry_tag;

   modport source (output valid, output operation, output start_time, output end_time,
                   output entry_tag, input ready);
   modport sink   (input valid, input operation, input start_time, input end_time,
                   input entry_tag, output ready);
endinterface

interface sirt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          status;
   logic [sirt_pkg::TIME_BITS-1:0]      found_end;
   logic [sirt_pkg::TAG_IN_BITS-1:0]    found_tag;
   logic [sirt_pkg::COUNT_BITS-1:0]     entry_count;

   modport source (output valid, output status, output found_end, output found_tag,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input found_end, input found_tag,
                   input entry_count, output ready);
endinterface

// File: sv/sirt_ram.sv
module sirt_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// File: sv/sorted_interval_reservation_table.sv
// Sorted interval reservation table. The block holds up to CAPACITY intervals
// [start, end), each with a tag, kept sorted by start time and never
// overlapping; intervals that only touch are accepted. A request is an insert,
// a remove by start time, or a find by start time, and every request returns
// exactly one response carrying a status, the end and tag of a found entry,
// and the number of stored entries afterwards. Entries live in one
// single-port-read, single-port-write RAM, and a small sequencer walks it one
// entry per cycle: a scan pass reads every stored entry, and an accepted insert
// or a remove that found its entry then runs a shift pass that opens or closes
// the gap, moving each entry above that point by one place. A rejected insert
// of an empty or reversed interval and the unknown operation skip both passes
// and go straight to the response. The block takes one request at a time; a
// finished response sits in an output register, so the next request may be
// taken before it is drained.
module sorted_interval_reservation_table #(
   parameter int CAPACITY = 16,
   parameter int TAG_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   sirt_req_if.sink   req_chan,
   sirt_rsp_if.source rsp_chan
);

   import sirt_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = 2 * TIME_BITS + TAG_BITS;

   // Sequencer state.
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;

   // Captured request.
   op_type               op_ff, op_in;
   logic [TIME_BITS-1:0] s_ff, s_in;
   logic [TIME_BITS-1:0] e_ff, e_in;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   // Scan pass bookkeeping.
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        chk_ff, chk_in;
   logic                 clash_ff, clash_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic [AW-1:0]        match_ff, match_in;
   logic [TIME_BITS-1:0] fend_ff, fend_in;
   logic [TAG_BITS-1:0]  ftag_ff, ftag_in;

   // Shift pass bookkeeping.
   logic [AW-1:0]        src_ff, src_in;
   logic [AW-1:0]        dst_ff, dst_in;
   logic [CW-1:0]        left_ff, left_in;

   status_type           status_ff, status_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [TIME_BITS-1:0] rsp_end_ff, rsp_end_in;
   logic [TAG_IN_BITS-1:0] rsp_tag_ff, rsp_tag_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   // Entry RAM ports.
   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [EW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [EW-1:0] ram_rd_data;

   logic [TIME_BITS-1:0] rd_start;
   logic [TIME_BITS-1:0] rd_end;
   logic [TAG_BITS-1:0]  rd_tag;

   // Width adapters between the fixed port fields and the parameterized store.
   logic [TAG_BITS+TAG_IN_BITS-1:0] tag_req_wide;
   logic [TAG_BITS+TAG_IN_BITS-1:0] tag_rsp_wide;
   logic [CW+COUNT_BITS-1:0]        count_wide;
   logic                            find_hit;

   assign rd_start = ram_rd_data[EW-1 -: TIME_BITS];
   assign rd_end   = ram_rd_data[EW-TIME_BITS-1 -: TIME_BITS];
   assign rd_tag   = ram_rd_data[TAG_BITS-1:0];

   assign tag_req_wide = {{TAG_BITS{1'b0}}, req_chan.entry_tag};
   assign tag_rsp_wide = {{TAG_IN_BITS{1'b0}}, ftag_ff};
   assign count_wide   = {{COUNT_BITS{1'b0}}, count_ff};
   assign find_hit     = (op_ff == OP_FIND) && (status_ff == STATUS_OK);

   sirt_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      tag_in        = tag_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      chk_in        = chk_ff;
      clash_in      = clash_ff;
      pos_in        = pos_ff;
      found_in      = found_ff;
      match_in      = match_ff;
      fend_in       = fend_ff;
      ftag_in       = ftag_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      left_in       = left_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = dst_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = src_ff;
      req_chan.ready = 1'b0;

      // The response register drains independently of the sequencer.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         STATE_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               op_in     = op_type'(req_chan.operation);
               s_in      = req_chan.start_time;
               e_in      = req_chan.end_time;
               tag_in    = tag_req_wide[TAG_BITS-1:0];
               idx_in    = '0;
               pend_in   = 1'b0;
               clash_in  = 1'b0;
               pos_in    = '0;
               found_in  = 1'b0;
               status_in = STATUS_OK;
               state_in  = STATE_SCAN;
               // An empty or reversed interval is refused before any lookup.
               if ((op_type'(req_chan.operation) == OP_INSERT &&
                    req_chan.end_time <= req_chan.start_time) ||
                   op_type'(req_chan.operation) == OP_RESERVED) begin
                  status_in = STATUS_ILLEGAL;
                  state_in  = STATE_DONE;
               end
            end
         end

         STATE_SCAN: begin
            // Check the entry whose read was issued last cycle.
            if (pend_ff) begin
               if (op_ff == OP_INSERT) begin
                  if (s_ff < rd_end && e_ff > rd_start) begin
                     clash_in = 1'b1;
                  end
                  if (rd_start < s_ff) begin
                     pos_in = pos_ff + 1'b1;
                  end
               end else if (!found_ff && rd_start == s_ff) begin
                  found_in = 1'b1;
                  match_in = chk_ff;
                  fend_in  = rd_end;
                  ftag_in  = rd_tag;
               end
            end
            if (idx_ff < count_ff) begin
               ram_rd_addr = idx_ff[AW-1:0];
               chk_in      = idx_ff[AW-1:0];
               idx_in      = idx_ff + 1'b1;
               pend_in     = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = STATE_DONE;
               if (op_ff == OP_INSERT) begin
                  if (clash_in) begin
                     status_in = STATUS_TAKEN;
                  end else if (count_ff == CW'(CAPACITY)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // Open a gap at the insertion point, moving from the top.
                     left_in  = count_ff - pos_in;
                     src_in   = AW'(count_ff - 1'b1);
                     state_in = STATE_SHIFT;
                  end
               end else if (!found_in) begin
                  status_in = STATUS_MISSING;
               end else if (op_ff == OP_REMOVE) begin
                  // Close the gap left by the matched entry, moving from below.
                  left_in  = count_ff - 1'b1 - CW'(match_in);
                  src_in   = match_in + 1'b1;
                  state_in = STATE_SHIFT;
               end
            end
         end

         STATE_SHIFT: begin
            if (pend_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = dst_ff;
               ram_wr_data = ram_rd_data;
            end
            if (left_ff != '0) begin
               ram_rd_addr = src_ff;
               pend_in     = 1'b1;
               left_in     = left_ff - 1'b1;
               if (op_ff == OP_INSERT) begin
                  dst_in = src_ff + 1'b1;
                  src_in = src_ff - 1'b1;
               end else begin
                  dst_in = src_ff - 1'b1;
                  src_in = src_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
               if (op_ff == OP_INSERT) begin
                  state_in = STATE_PLACE;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = STATE_DONE;
               end
            end
         end

         STATE_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = {s_ff, e_ff, tag_ff};
            count_in    = count_ff + 1'b1;
            state_in    = STATE_DONE;
         end

         STATE_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_end_in    = find_hit ? fend_ff : '0;
               rsp_tag_in    = find_hit ? tag_rsp_wide[TAG_IN_BITS-1:0] : '0;
               rsp_count_in  = count_wide[COUNT_BITS-1:0];
               state_in      = STATE_IDLE;
            end
         end

         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      tag_ff        <= tag_in;
      idx_ff        <= idx_in;
      chk_ff        <= chk_in;
      clash_ff      <= clash_in;
      pos_ff        <= pos_in;
      found_ff      <= found_in;
      match_ff      <= match_in;
      fend_ff       <= fend_in;
      ftag_ff       <= ftag_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      left_ff       <= left_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_end   = rsp_end_ff;
   assign rsp_chan.found_tag   = rsp_tag_ff;
   assign rsp_chan.entry_count = rsp_count_ff;

endmodule
